### hdl/bitmap_block_allocator_top_assert.svh
// Assertion macros for the bitmap block allocator checker.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Used by the cell, controller, top level and checker; no dependencies.
package bba_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int RUN_W          = 7;
	localparam int IDX_W          = 6;
	localparam int CNT_W          = 7;
	localparam int ST_W           = 3;
	localparam int IN_TDATA_W     = 16;
	localparam int OUT_TDATA_W    = 16;

	typedef enum logic [ST_W-1:0] {
		ST_OK          = 3'd0,
		ST_INVALID     = 3'd1,
		ST_TOO_FEW     = 3'd2,
		ST_NO_RUN      = 3'd3,
		ST_DOUBLE_FREE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT,
		OP_SHIFT_CLR,
		OP_COMMIT,
		OP_DROP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     mark;
	} cell_ctrl_t;

endpackage

### hdl/bitmap_block_allocator_top.sv
// Top level of the first-fit bitmap block allocator: a ring of bba_cell
// and the bba_ctrl sequencer. Depends on bba_pkg, bba_cell, bba_ctrl.
//
// channel | dir | tdata (low bit up)                     | tuser
// s_*     | in  | run_length[6:0] block_index[12:7] pad  | action
// m_*     | out | status[2:0] start_index[8:3] free[15:9]| -
//
// Release and rejected requests pass through S_EXEC and S_RESP into the result
// register; the sequencer takes no new beat until it is back in S_IDLE.
// An allocate that reaches the scan also runs S_SCAN and S_DONE; the bitmap
// ring rotates one cell per cycle past the head cell, tagging the candidate run.
// Reset sets every block free; no clearing pass. A stalled result lets one
// more request run, which then waits in the sequencer until the first is taken.
module bitmap_block_allocator_top #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// run_length[6:0], block_index[12:7], zero pad [15:13]
	input  logic [bba_pkg::IN_TDATA_W-1:0]    s_tdata,
	// action[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[2:0], start_index[8:3], free_count[15:9]
	output logic [bba_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	bba_pkg::cell_ctrl_t          ctrl;
	logic [NUM_BLOCKS-1:0]        rel_set;
	logic [NUM_BLOCKS-1:0]        free_vec;
	logic [NUM_BLOCKS-1:0]        pend_vec;
	logic [NUM_BLOCKS-1:0]        free_nxt;
	logic [NUM_BLOCKS-1:0]        pend_nxt;
	logic [bba_pkg::ST_W-1:0]     rsp_status;
	logic [bba_pkg::IDX_W-1:0]    rsp_start;
	logic [bba_pkg::CNT_W-1:0]    rsp_count;

	// ring: each cell takes its upper neighbor, the top cell takes the head
	assign free_nxt = {free_vec[0], free_vec[NUM_BLOCKS-1:1]};
	assign pend_nxt = {pend_vec[0] | ctrl.mark, pend_vec[NUM_BLOCKS-1:1]};

	for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
		bba_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.rel_set (rel_set[i]),
			.free_in (free_nxt[i]),
			.pend_in (pend_nxt[i]),
			.free    (free_vec[i]),
			.pend    (pend_vec[i])
		);
	end

	bba_ctrl #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.req_action (s_tuser),
		.req_len    (s_tdata[6:0]),
		.req_idx    (s_tdata[12:7]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.rsp_status (rsp_status),
		.rsp_start  (rsp_start),
		.rsp_count  (rsp_count),
		.free_vec   (free_vec),
		.ctrl       (ctrl),
		.rel_set    (rel_set)
	);

	assign m_tdata = {rsp_count, rsp_start, rsp_status};

endmodule

### hdl/bba_cell.sv
// One bitmap cell: a free bit and a pending-allocation bit.
// Shifts toward its lower neighbor on scan; depends on bba_pkg.
module bba_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bba_pkg::cell_ctrl_t ctrl,
	input  logic                rel_set,
	input  logic                free_in,
	input  logic                pend_in,
	output logic                free,
	output logic                pend
);

	logic free_q;
	logic pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= 1'b1;
			pend_q <= 1'b0;
		end else if (rel_set) begin
			free_q <= 1'b1;
		end else begin
			unique case (ctrl.op)
				bba_pkg::OP_SHIFT: begin
					free_q <= free_in;
					pend_q <= pend_in;
				end
				bba_pkg::OP_SHIFT_CLR: begin
					free_q <= free_in;
					pend_q <= 1'b0;
				end
				bba_pkg::OP_COMMIT: begin
					free_q <= free_q & ~pend_q;
					pend_q <= 1'b0;
				end
				bba_pkg::OP_DROP: begin
					pend_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign free = free_q;
	assign pend = pend_q;

endmodule

### hdl/bba_ctrl.sv
// Request sequencer: decodes beats, drives the cell row scan, keeps the
// free count and holds the result register. Depends on bba_pkg.
module bba_ctrl #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic                         req_action,
	input  logic [bba_pkg::RUN_W-1:0]    req_len,
	input  logic [bba_pkg::IDX_W-1:0]    req_idx,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bba_pkg::ST_W-1:0]     rsp_status,
	output logic [bba_pkg::IDX_W-1:0]    rsp_start,
	output logic [bba_pkg::CNT_W-1:0]    rsp_count,
	input  logic [NUM_BLOCKS-1:0]        free_vec,
	output bba_pkg::cell_ctrl_t          ctrl,
	output logic [NUM_BLOCKS-1:0]        rel_set
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam logic [bba_pkg::CNT_W-1:0] NB = bba_pkg::CNT_W'(NUM_BLOCKS);
	localparam logic [IW-1:0] LAST = IW'(NUM_BLOCKS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DONE,
		S_RESP
	} state_t;

	state_t                       state_q;
	logic                         act_q;
	logic [bba_pkg::RUN_W-1:0]    len_q;
	logic [bba_pkg::IDX_W-1:0]    idx_q;
	logic [bba_pkg::CNT_W-1:0]    cnt_q;
	logic [bba_pkg::RUN_W-1:0]    run_q;
	logic [IW-1:0]                pos_q;
	logic                         found_q;
	logic [bba_pkg::IDX_W-1:0]    start_q;
	bba_pkg::status_t             status_q;
	logic                         m_tvalid_q;
	logic [bba_pkg::ST_W-1:0]     out_status_q;
	logic [bba_pkg::IDX_W-1:0]    out_start_q;
	logic [bba_pkg::CNT_W-1:0]    out_cnt_q;

	logic                         head_free;
	logic                         hit;
	logic                         idx_ok;
	logic [IW-1:0]                idx_lo;
	logic                         len_bad;
	logic [bba_pkg::RUN_W-1:0]    start_calc;
	logic                         rsp_load;

	assign head_free  = free_vec[0];
	assign hit        = head_free && ((run_q + bba_pkg::RUN_W'(1)) == len_q);
	assign idx_ok     = bba_pkg::CNT_W'(idx_q) < NB;
	assign idx_lo     = idx_q[IW-1:0];
	assign len_bad    = (len_q == '0) || (len_q > NB);
	assign start_calc = bba_pkg::RUN_W'(pos_q) + bba_pkg::RUN_W'(1) - len_q;
	assign rsp_load   = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	always_comb begin
		ctrl.op   = bba_pkg::OP_HOLD;
		ctrl.mark = 1'b0;
		rel_set   = '0;
		unique case (state_q)
			S_SCAN: begin
				if (found_q || head_free) begin
					ctrl.op = bba_pkg::OP_SHIFT;
				end else begin
					ctrl.op = bba_pkg::OP_SHIFT_CLR;
				end
				ctrl.mark = !found_q && head_free;
			end
			S_DONE: begin
				ctrl.op = found_q ? bba_pkg::OP_COMMIT : bba_pkg::OP_DROP;
			end
			S_EXEC: begin
				if (act_q && idx_ok && !free_vec[idx_lo]) begin
					rel_set = {{(NUM_BLOCKS-1){1'b0}}, 1'b1} << idx_lo;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= NB;
			m_tvalid_q   <= 1'b0;
			found_q      <= 1'b0;
			run_q        <= '0;
			pos_q        <= '0;
			status_q     <= bba_pkg::ST_OK;
			act_q        <= 1'b0;
			len_q        <= '0;
			idx_q        <= '0;
			start_q      <= '0;
			out_status_q <= '0;
			out_start_q  <= '0;
			out_cnt_q    <= '0;
		end else begin
			if (rsp_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q   <= req_action;
						len_q   <= req_len;
						idx_q   <= req_idx;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					start_q <= '0;
					run_q   <= '0;
					pos_q   <= '0;
					found_q <= 1'b0;
					if (act_q) begin
						state_q <= S_RESP;
						if (!idx_ok) begin
							status_q <= bba_pkg::ST_INVALID;
						end else if (free_vec[idx_lo]) begin
							status_q <= bba_pkg::ST_DOUBLE_FREE;
						end else begin
							status_q <= bba_pkg::ST_OK;
							cnt_q    <= cnt_q + bba_pkg::CNT_W'(1);
						end
					end else if (len_bad) begin
						status_q <= bba_pkg::ST_INVALID;
						state_q  <= S_RESP;
					end else if (cnt_q < len_q) begin
						status_q <= bba_pkg::ST_TOO_FEW;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!found_q) begin
						if (head_free) begin
							run_q <= run_q + bba_pkg::RUN_W'(1);
							if (hit) begin
								found_q <= 1'b1;
								start_q <= start_calc[bba_pkg::IDX_W-1:0];
							end
						end else begin
							run_q <= '0;
						end
					end
					pos_q <= pos_q + IW'(1);
					if (pos_q == LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (found_q) begin
						status_q <= bba_pkg::ST_OK;
						cnt_q    <= cnt_q - len_q;
					end else begin
						status_q <= bba_pkg::ST_NO_RUN;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						out_status_q <= status_q;
						out_start_q  <= start_q;
						out_cnt_q    <= cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign rsp_status = out_status_q;
	assign rsp_start  = out_start_q;
	assign rsp_count  = out_cnt_q;

endmodule

### hdl/bba_checker.sv
// Port-level checker for bitmap_block_allocator_top, bound to every instance.
// Depends on bba_pkg and bitmap_block_allocator_top_assert.svh.
`include "bitmap_block_allocator_top_assert.svh"

module bba_checker #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [bba_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam logic [bba_pkg::CNT_W-1:0] NB = bba_pkg::CNT_W'(NUM_BLOCKS);

	`BBA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`BBA_ASSERT_NOW(a_status, m_tvalid, m_tdata[2:0] <= bba_pkg::ST_DOUBLE_FREE, "bad status")
	`BBA_ASSERT_NOW(a_start, m_tvalid && (m_tdata[2:0] != bba_pkg::ST_OK), m_tdata[8:3] == '0, "start not zero")
	`BBA_ASSERT_NOW(a_count, m_tvalid, m_tdata[15:9] <= NB, "free count above block count")
	`BBA_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "beat taken while busy")

endmodule

bind bitmap_block_allocator_top bba_checker #(
	.NUM_BLOCKS (NUM_BLOCKS)
) u_bba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### bench/tb_top.sv
// Self-checking bench for bitmap_block_allocator_top: directed table plus random requests,
// each result checked against its table entry or a first-fit bitmap predictor held in the bench.
// Depends on bba_pkg and bitmap_block_allocator_top.
module tb_top;

	localparam int NB            = bba_pkg::NUM_BLOCKS_DEF;
	localparam int RUN_W         = bba_pkg::RUN_W;
	localparam int IDX_W         = bba_pkg::IDX_W;
	localparam int CNT_W         = bba_pkg::CNT_W;
	localparam int RANDOM_ITEMS  = 1430;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int IDLE_PCT      = 17;
	localparam int HOLD_AT       = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int RX_QUIET_FROM = 8000;
	localparam int RX_QUIET_TO   = 13000;
	localparam int TX_QUIET_FROM = 600;
	localparam int TX_QUIET_TO   = 800;
	localparam int DRAIN_CYCLES  = NB + 8;
	localparam int NUM_ROWS      = 24;

	typedef enum logic {
		ACT_ALLOC   = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef struct packed {
		bba_pkg::status_t status;
		logic [IDX_W-1:0] start;
		logic [CNT_W-1:0] free;
	} grant_t;

	typedef struct {
		action_t          act;
		logic [RUN_W-1:0] len;
		logic [IDX_W-1:0] idx;
		bit               typed;
		grant_t           want;
	} stim_row_t;

	// typed rows carry their result; the rest go through the predictor
	stim_row_t directed_rows [NUM_ROWS] = '{
		'{ACT_ALLOC,   7'd0,   6'd63, 1'b1, '{bba_pkg::ST_INVALID,     6'd0, 7'd16}},
		'{ACT_ALLOC,   7'd17,  6'd0,  1'b1, '{bba_pkg::ST_INVALID,     6'd0, 7'd16}},
		'{ACT_ALLOC,   7'd127, 6'd42, 1'b1, '{bba_pkg::ST_INVALID,     6'd0, 7'd16}},
		'{ACT_RELEASE, 7'd127, 6'd16, 1'b1, '{bba_pkg::ST_INVALID,     6'd0, 7'd16}},
		'{ACT_RELEASE, 7'd0,   6'd63, 1'b1, '{bba_pkg::ST_INVALID,     6'd0, 7'd16}},
		'{ACT_RELEASE, 7'd1,   6'd0,  1'b1, '{bba_pkg::ST_DOUBLE_FREE, 6'd0, 7'd16}},
		'{ACT_RELEASE, 7'd64,  6'd15, 1'b1, '{bba_pkg::ST_DOUBLE_FREE, 6'd0, 7'd16}},
		'{ACT_ALLOC,   7'd16,  6'd21, 1'b1, '{bba_pkg::ST_OK,          6'd0, 7'd0}},
		'{ACT_ALLOC,   7'd1,   6'd0,  1'b1, '{bba_pkg::ST_TOO_FEW,     6'd0, 7'd0}},
		'{ACT_RELEASE, 7'd0,   6'd5,  1'b1, '{bba_pkg::ST_OK,          6'd0, 7'd1}},
		'{ACT_ALLOC,   7'd1,   6'd0,  1'b1, '{bba_pkg::ST_OK,          6'd5, 7'd0}},
		'{ACT_RELEASE, 7'd0,   6'd0,  1'b1, '{bba_pkg::ST_OK,          6'd0, 7'd1}},
		'{ACT_RELEASE, 7'd0,   6'd15, 1'b1, '{bba_pkg::ST_OK,          6'd0, 7'd2}},
		'{ACT_ALLOC,   7'd2,   6'd0,  1'b1, '{bba_pkg::ST_NO_RUN,      6'd0, 7'd2}},
		'{ACT_ALLOC,   7'd3,   6'd0,  1'b1, '{bba_pkg::ST_TOO_FEW,     6'd0, 7'd2}},
		'{ACT_RELEASE, 7'd0,   6'd15, 1'b1, '{bba_pkg::ST_DOUBLE_FREE, 6'd0, 7'd2}},
		'{ACT_RELEASE, 7'd0,   6'd8,  1'b0, '0},
		'{ACT_RELEASE, 7'd0,   6'd7,  1'b0, '0},
		'{ACT_ALLOC,   7'd2,   6'd0,  1'b0, '0},
		'{ACT_ALLOC,   7'd1,   6'd0,  1'b0, '0},
		'{ACT_ALLOC,   7'd1,   6'd0,  1'b0, '0},
		'{ACT_RELEASE, 7'd0,   6'd3,  1'b0, '0},
		'{ACT_RELEASE, 7'd0,   6'd4,  1'b0, '0},
		'{ACT_ALLOC,   7'd2,   6'd0,  1'b0, '0}
	};

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [bba_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                            s_tuser  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [bba_pkg::OUT_TDATA_W-1:0] m_tdata;

	logic [NB-1:0] vacancy_map = '1;
	grant_t        pending_grants [$];
	int            cycle_count    = 0;
	int            error_count    = 0;
	int            requests_sent  = 0;
	int            grants_seen    = 0;
	int            status_seen [5] = '{default: 0};

	bitmap_block_allocator_top #(.NUM_BLOCKS(NB)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_grants.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic note_mismatch(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		error_count++;
	endtask

	// first-fit allocate / single release on the bench's copy of the bitmap
	function automatic grant_t predict_grant(input action_t act, input logic [RUN_W-1:0] len,
			input logic [IDX_W-1:0] idx);
		grant_t r;
		int     run;
		bit     found;
		r.status = bba_pkg::ST_OK;
		r.start  = '0;
		run      = 0;
		found    = 1'b0;
		if (act == ACT_ALLOC) begin
			if (len == 0 || len > NB) begin
				r.status = bba_pkg::ST_INVALID;
			end else if ($countones(vacancy_map) < len) begin
				r.status = bba_pkg::ST_TOO_FEW;
			end else begin
				for (int i = 0; i < NB && !found; i++) begin
					if (vacancy_map[i]) begin
						run++;
						if (run == len) begin
							r.start = IDX_W'(i + 1 - len);
							for (int j = i + 1 - len; j <= i; j++)
								vacancy_map[j] = 1'b0;
							found = 1'b1;
						end
					end else begin
						run = 0;
					end
				end
				if (!found)
					r.status = bba_pkg::ST_NO_RUN;
			end
		end else begin
			if (idx >= NB)
				r.status = bba_pkg::ST_INVALID;
			else if (vacancy_map[idx])
				r.status = bba_pkg::ST_DOUBLE_FREE;
			else
				vacancy_map[idx] = 1'b1;
		end
		r.free = CNT_W'($countones(vacancy_map));
		return r;
	endfunction

	// mostly well-formed traffic: fitting allocates and frees of used blocks, some noise
	task automatic pick_request(output action_t act, output logic [RUN_W-1:0] len,
			output logic [IDX_W-1:0] idx);
		int vacant;
		int roll;
		int rel_share;
		vacant    = $countones(vacancy_map);
		roll      = $urandom_range(99);
		rel_share = (vacant < 4) ? 70 : ((vacant > 12) ? 20 : 42);
		act       = ACT_ALLOC;
		len       = RUN_W'($urandom_range(127));
		idx       = IDX_W'($urandom_range(63));
		if (roll < 10) begin
			case ($urandom_range(3))
				0: len = '0;
				1: len = RUN_W'($urandom_range(127, NB + 1));
				2: begin
					act = ACT_RELEASE;
					idx = IDX_W'($urandom_range(63, NB));
				end
				default: begin
					act = ACT_RELEASE;
					idx = IDX_W'($urandom_range(NB - 1));
				end
			endcase
		end else if (roll < 10 + rel_share) begin
			act = ACT_RELEASE;
			idx = IDX_W'($urandom_range(NB - 1));
			if (vacant < NB)
				while (vacancy_map[idx])
					idx = IDX_W'($urandom_range(NB - 1));
		end else if ($urandom_range(99) < 65) begin
			len = RUN_W'($urandom_range(4, 1));
		end else begin
			len = RUN_W'($urandom_range(NB, 1));
		end
	endtask

	task automatic offer(input action_t act, input logic [RUN_W-1:0] len,
			input logic [IDX_W-1:0] idx, input bit typed, input grant_t want, input bit may_idle);
		grant_t predicted;
		while (may_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, idx, len};
		do @(posedge clk); while (!s_tready);
		predicted = predict_grant(act, len, idx);
		pending_grants.push_back(typed ? want : predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	// receiver: random back-pressure, one long hold-off, one stretch always ready
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cycle_count == HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (cycle_count >= RX_QUIET_FROM && cycle_count < RX_QUIET_TO) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		grant_t got;
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = bba_pkg::status_t'(m_tdata[2:0]);
			got.start  = m_tdata[8:3];
			got.free   = m_tdata[15:9];
			if (got.status <= bba_pkg::ST_DOUBLE_FREE)
				status_seen[got.status]++;
			if (pending_grants.size() == 0) begin
				note_mismatch($sformatf("result beat %0d with nothing expected, tdata %h",
					grants_seen, m_tdata));
			end else begin
				want = pending_grants.pop_front();
				if (got.status !== want.status)
					note_mismatch($sformatf("beat %0d status %0d, want %0d", grants_seen,
						got.status, want.status));
				if (got.start !== want.start)
					note_mismatch($sformatf("beat %0d start_index %0d, want %0d", grants_seen,
						got.start, want.start));
				if (got.free !== want.free)
					note_mismatch($sformatf("beat %0d free_count %0d, want %0d", grants_seen,
						got.free, want.free));
			end
			grants_seen++;
		end
	end

	initial begin
		action_t          act;
		logic [RUN_W-1:0] len;
		logic [IDX_W-1:0] idx;
		bit               quiet;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			offer(directed_rows[r].act, directed_rows[r].len, directed_rows[r].idx,
				directed_rows[r].typed, directed_rows[r].want, 1'b1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300 || i == 1100) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
				while (pending_grants.size() != 0) @(negedge clk);
			end
			quiet = (i >= TX_QUIET_FROM && i < TX_QUIET_TO);
			pick_request(act, len, idx);
			offer(act, len, idx, 1'b0, '0, !quiet);
		end
		s_tvalid <= 1'b0;

		while (pending_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_grants.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_grants.size()));

		$display("%0d requests (%0d from the table), %0d results in %0d cycles", requests_sent,
			NUM_ROWS, grants_seen, cycle_count);
		$display("status mix: ok %0d, invalid %0d, too few %0d, no run %0d, double free %0d",
			status_seen[bba_pkg::ST_OK], status_seen[bba_pkg::ST_INVALID],
			status_seen[bba_pkg::ST_TOO_FEW], status_seen[bba_pkg::ST_NO_RUN],
			status_seen[bba_pkg::ST_DOUBLE_FREE]);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### bitmap_block_allocator_top.f
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_cell.sv
hdl/bba_ctrl.sv
hdl/bitmap_block_allocator_top.sv
hdl/bba_checker.sv
bench/tb_top.sv
